### rtl/core/source_byte_tokenizer_top_defines.svh
// Assertion macros shared by the tokenizer checker.
`ifndef SOURCE_BYTE_TOKENIZER_TOP_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SBT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

### rtl/core/sbt_pkg.sv
package sbt_pkg;

  // Field widths.
  localparam int ByteW = 8;
  localparam int KindW = 5;
  localparam int PosW  = 17;
  localparam int LineW = 16;
  localparam int MaxResults = 3;

  // Positions saturate at the maximum text length.
  localparam logic [PosW-1:0]  MaxPos  = PosW'(65536);
  localparam logic [LineW-1:0] LineMax = '1;

  // Token kinds; punctuation kinds come from a table in the scanner.
  localparam logic [KindW-1:0] KindLine    = 5'd0;
  localparam logic [KindW-1:0] KindComment = 5'd1;
  localparam logic [KindW-1:0] KindString  = 5'd2;
  localparam logic [KindW-1:0] KindLabel   = 5'd3;
  localparam logic [KindW-1:0] KindNumber  = 5'd4;
  localparam logic [KindW-1:0] KindNone    = 5'd0;

  // Scanner modes.
  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeSlash   = 3'd1,
    ModeComment = 3'd2,
    ModeString  = 3'd3,
    ModeEscape  = 3'd4,
    ModeLabel   = 3'd5,
    ModeNumber  = 3'd6
  } mode_e;

  // One token.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  start_pos;
    logic [PosW-1:0]  end_pos;
    logic [LineW-1:0] line;
  } tok_t;

  // All tokens caused by one byte, in order.
  typedef struct packed {
    logic [1:0]             count;
    tok_t [MaxResults-1:0]  tok;
  } step_t;

endpackage

### rtl/core/sbt_scan.sv
module sbt_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [sbt_pkg::ByteW-1:0] byte_i,
  input  logic                      eot_i,
  input  logic                      commit_i,
  output sbt_pkg::step_t            step_o
);
  import sbt_pkg::*;

  localparam logic [ByteW-1:0] ChSlash  = 8'h2F;
  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChUnder  = 8'h5F;
  localparam logic [ByteW-1:0] ChDot    = 8'h2E;
  localparam logic [ByteW-1:0] ChNl     = 8'h0A;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_label_start(input logic [ByteW-1:0] c);
    return (c == ChUnder) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic [KindW-1:0] punct_kind(input logic [ByteW-1:0] c);
    logic [KindW-1:0] k;
    unique case (c)
      8'h2B:   k = 5'd5;
      8'h2A:   k = 5'd6;
      8'h3D:   k = 5'd7;
      8'h40:   k = 5'd8;
      8'h24:   k = 5'd9;
      8'h2E:   k = 5'd10;
      8'h2C:   k = 5'd11;
      8'h3B:   k = 5'd12;
      8'h28:   k = 5'd13;
      8'h29:   k = 5'd14;
      8'h5B:   k = 5'd15;
      8'h5D:   k = 5'd16;
      8'h7B:   k = 5'd17;
      8'h7D:   k = 5'd18;
      default: k = KindNone;
    endcase
    return k;
  endfunction

  function automatic tok_t mk_tok(input logic [KindW-1:0] k, input logic [PosW-1:0] s,
                                  input logic [PosW-1:0] e, input logic [LineW-1:0] l);
    tok_t t;
    t.kind      = k;
    t.start_pos = s;
    t.end_pos   = e;
    t.line      = l;
    return t;
  endfunction

  mode_e            mode_q, mode_d;
  logic [PosW-1:0]  begin_q, begin_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [LineW-1:0] line_q, line_d;
  logic             lht_q, lht_d;
  step_t            step_d;

  // Scan one byte: next state and the tokens it causes.
  always_comb begin
    logic [PosW-1:0]  p;
    logic [PosW-1:0]  np;
    logic [LineW-1:0] cur;
    logic             rescan;
    logic [KindW-1:0] pk;
    p       = pos_q;
    np      = (pos_q < MaxPos) ? pos_q + PosW'(1) : MaxPos;
    mode_d  = mode_q;
    begin_d = begin_q;
    line_d  = line_q;
    lht_d   = lht_q;
    pos_d   = np;
    step_d  = '0;
    rescan  = 1'b0;
    cur     = '0;
    pk      = punct_kind(byte_i);

    // Close or continue the token in progress.
    unique case (mode_q)
      ModeSlash: begin
        if (byte_i == ChSlash) begin
          mode_d = ModeComment;
        end else begin
          rescan = 1'b1;
        end
      end
      ModeComment: begin
        if (byte_i == ChNl) begin
          cur = (line_d != LineMax) ? line_d + LineW'(1) : LineMax;
          step_d.tok[step_d.count] = mk_tok(KindComment, begin_d, p, cur);
          step_d.count = step_d.count + 2'd1;
          if (line_d != LineMax) begin
            line_d = line_d + LineW'(1);
          end
          step_d.tok[step_d.count] = mk_tok(KindLine, p, np, line_d);
          step_d.count = step_d.count + 2'd1;
          lht_d  = 1'b0;
          mode_d = ModeIdle;
        end
      end
      ModeString: begin
        if (byte_i == ChQuote) begin
          cur = (line_d != LineMax) ? line_d + LineW'(1) : LineMax;
          step_d.tok[step_d.count] = mk_tok(KindString, begin_d, p, cur);
          step_d.count = step_d.count + 2'd1;
          lht_d  = 1'b1;
          mode_d = ModeIdle;
        end else if (byte_i == ChBslash) begin
          mode_d = ModeEscape;
        end
      end
      ModeEscape: begin
        mode_d = ModeString;
      end
      ModeLabel: begin
        if (!(is_digit(byte_i) || is_label_start(byte_i))) begin
          cur = (line_d != LineMax) ? line_d + LineW'(1) : LineMax;
          step_d.tok[step_d.count] = mk_tok(KindLabel, begin_d, p, cur);
          step_d.count = step_d.count + 2'd1;
          lht_d  = 1'b1;
          rescan = 1'b1;
        end
      end
      ModeNumber: begin
        if (!(is_digit(byte_i) || (byte_i == ChDot))) begin
          cur = (line_d != LineMax) ? line_d + LineW'(1) : LineMax;
          step_d.tok[step_d.count] = mk_tok(KindNumber, begin_d, p, cur);
          step_d.count = step_d.count + 2'd1;
          lht_d  = 1'b1;
          rescan = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // Scan the byte from the idle mode.
    if (rescan) begin
      mode_d = ModeIdle;
      priority if (byte_i == ChNl) begin
        if (line_d != LineMax) begin
          line_d = line_d + LineW'(1);
        end
        step_d.tok[step_d.count] = mk_tok(KindLine, p, np, line_d);
        step_d.count = step_d.count + 2'd1;
        lht_d = 1'b0;
      end else if (byte_i == ChSlash) begin
        mode_d  = ModeSlash;
        begin_d = p;
      end else if (byte_i == ChQuote) begin
        mode_d  = ModeString;
        begin_d = np;
      end else if (is_label_start(byte_i)) begin
        mode_d  = ModeLabel;
        begin_d = p;
      end else if (is_digit(byte_i)) begin
        mode_d  = ModeNumber;
        begin_d = p;
      end else begin
        // Punctuation is a token of its own; any other byte is skipped.
        if (pk != KindNone) begin
          cur = (line_d != LineMax) ? line_d + LineW'(1) : LineMax;
          step_d.tok[step_d.count] = mk_tok(pk, p, np, cur);
          step_d.count = step_d.count + 2'd1;
          lht_d = 1'b1;
        end
      end
    end

    // End of text: flush the pending token and the open line, then restart.
    if (eot_i) begin
      cur = (line_d != LineMax) ? line_d + LineW'(1) : LineMax;
      unique case (mode_d)
        ModeComment: begin
          step_d.tok[step_d.count] = mk_tok(KindComment, begin_d, np, cur);
          step_d.count = step_d.count + 2'd1;
          lht_d = 1'b1;
        end
        ModeString, ModeEscape: begin
          step_d.tok[step_d.count] = mk_tok(KindString, begin_d, np, cur);
          step_d.count = step_d.count + 2'd1;
          lht_d = 1'b1;
        end
        ModeLabel: begin
          step_d.tok[step_d.count] = mk_tok(KindLabel, begin_d, np, cur);
          step_d.count = step_d.count + 2'd1;
          lht_d = 1'b1;
        end
        ModeNumber: begin
          step_d.tok[step_d.count] = mk_tok(KindNumber, begin_d, np, cur);
          step_d.count = step_d.count + 2'd1;
          lht_d = 1'b1;
        end
        default: begin
        end
      endcase
      if (lht_d) begin
        step_d.tok[step_d.count] = mk_tok(KindLine, np, np, cur);
        step_d.count = step_d.count + 2'd1;
      end
      mode_d  = ModeIdle;
      begin_d = '0;
      pos_d   = '0;
      line_d  = '0;
      lht_d   = 1'b0;
    end
  end

  assign step_o = step_d;

  // Scanner state, updated when the byte is handed on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      begin_q <= '0;
      pos_q   <= '0;
      line_q  <= '0;
      lht_q   <= 1'b0;
    end else if (commit_i) begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      lht_q   <= lht_d;
    end
  end

endmodule

### rtl/core/sbt_out.sv
module sbt_out (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  sbt_pkg::step_t            step_i,
  input  logic                      stall_i,
  output logic                      valid_o,
  output logic                      free_o,
  output logic [sbt_pkg::KindW-1:0] token_kind_o,
  output logic [sbt_pkg::PosW-1:0]  start_pos_o,
  output logic [sbt_pkg::PosW-1:0]  end_pos_o,
  output logic [sbt_pkg::LineW-1:0] line_number_o,
  output logic                      last_of_run_o
);
  import sbt_pkg::*;

  tok_t [MaxResults-1:0] tok_q;
  logic [1:0]            cnt_q, cnt_d;
  logic [1:0]            idx_q, idx_d;
  logic                  last;
  logic                  taken;
  tok_t                  head;

  assign valid_o = (cnt_q != 2'd0);
  assign last    = (idx_q == (cnt_q - 2'd1));
  assign taken   = valid_o && !stall_i;
  assign free_o  = !valid_o || (taken && last);

  // Walk through the held tokens one request at a time.
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (taken) begin
      idx_d = idx_q + 2'd1;
      if (last) begin
        cnt_d = 2'd0;
        idx_d = 2'd0;
      end
    end
    if (load_i) begin
      cnt_d = step_i.count;
      idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Token payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tok_q <= step_i.tok;
    end
  end

  assign head          = tok_q[idx_q];
  assign token_kind_o  = head.kind;
  assign start_pos_o   = head.start_pos;
  assign end_pos_o     = head.end_pos;
  assign line_number_o = head.line;
  assign last_of_run_o = last;

endmodule

### rtl/core/source_byte_tokenizer_top.sv
// Source byte tokenizer.
// Input channel: one source byte per request on source_byte_i, with
// end_of_text_i set on the last byte of a text. Output channel: one token per
// request (kind, start and end position, line number), with last_of_run_o set
// on the last token caused by one byte. Both channels use valid and stall.
// A byte is held in an input register, scanned combinationally, and its tokens
// (zero to three) load a result register that is read out one per request.
// The tokens load as the byte leaves the input register, and the first is then
// on the output. Throughput is one byte per cycle while the result register
// can take the tokens; a byte that causes n tokens holds the output until
// all n are taken, so the rate is set by the output channel when tokens are
// dense. Bytes that cause no token pass without waiting for the output.
// When the receiver stalls, the held token stays steady, and the input stalls
// once a byte with tokens waits behind the result register.
// Reset clears the scanner to the idle mode at position zero and line zero,
// and empties both registers. After a byte with end_of_text_i the scanner
// returns to its reset state, so the next byte starts a new text.
module source_byte_tokenizer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [sbt_pkg::ByteW-1:0] source_byte_i,
  input  logic                      end_of_text_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [sbt_pkg::KindW-1:0] token_kind_o,
  output logic [sbt_pkg::PosW-1:0]  start_pos_o,
  output logic [sbt_pkg::PosW-1:0]  end_pos_o,
  output logic [sbt_pkg::LineW-1:0] line_number_o,
  output logic                      last_of_run_o
);
  import sbt_pkg::*;

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] byte_q;
  logic             eot_q;
  logic             accept;
  logic             advance;
  logic             out_free;
  step_t            step;

  // The held byte moves on when it causes no token or the result register frees.
  assign advance    = in_valid_q && ((step.count == 2'd0) || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= source_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  sbt_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_q),
    .eot_i    (eot_q),
    .commit_i (advance),
    .step_o   (step)
  );

  sbt_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance && (step.count != 2'd0)),
    .step_i        (step),
    .stall_i       (out_stall_i),
    .valid_o       (out_valid_o),
    .free_o        (out_free),
    .token_kind_o  (token_kind_o),
    .start_pos_o   (start_pos_o),
    .end_pos_o     (end_pos_o),
    .line_number_o (line_number_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### rtl/core/sbt_checker.sv
`include "source_byte_tokenizer_top_defines.svh"

module sbt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [sbt_pkg::ByteW-1:0] source_byte_i,
  input logic                      end_of_text_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [sbt_pkg::KindW-1:0] token_kind_o,
  input logic [sbt_pkg::PosW-1:0]  start_pos_o,
  input logic [sbt_pkg::PosW-1:0]  end_pos_o,
  input logic [sbt_pkg::LineW-1:0] line_number_o,
  input logic                      last_of_run_o
);
  import sbt_pkg::*;

  // A stalled token holds still.
  `SBT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(token_kind_o) && $stable(start_pos_o) && $stable(end_pos_o) && $stable(line_number_o) && $stable(last_of_run_o))

  // A stalled input request keeps its byte and its end flag.
  `SBT_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(source_byte_i) && $stable(end_of_text_i))

  // The input only waits behind a token that is on offer.
  `SBT_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o)

  // Line numbers count from one.
  `SBT_ASSERT_NOW(a_line_nonzero, clk_i, rst_ni, out_valid_o, line_number_o != '0)

  // A line end covers the newline, or nothing at the end of a text.
  `SBT_ASSERT_NOW(a_line_span, clk_i, rst_ni, out_valid_o && (token_kind_o == KindLine), (end_pos_o == start_pos_o) || (end_pos_o == start_pos_o + PosW'(1)))

endmodule

bind source_byte_tokenizer_top sbt_checker u_sbt_checker (.*);

### dv/tb_source_byte_tokenizer_top.sv
module tb_source_byte_tokenizer_top;
  import sbt_pkg::*;

  // Punctuation kinds, in the order the scanner numbers them.
  localparam logic [KindW-1:0] KindPlus         = 5'd5;
  localparam logic [KindW-1:0] KindStar         = 5'd6;
  localparam logic [KindW-1:0] KindEquals       = 5'd7;
  localparam logic [KindW-1:0] KindAt           = 5'd8;
  localparam logic [KindW-1:0] KindDollar       = 5'd9;
  localparam logic [KindW-1:0] KindDot          = 5'd10;
  localparam logic [KindW-1:0] KindComma        = 5'd11;
  localparam logic [KindW-1:0] KindSemicolon    = 5'd12;
  localparam logic [KindW-1:0] KindParenOpen    = 5'd13;
  localparam logic [KindW-1:0] KindParenClose   = 5'd14;
  localparam logic [KindW-1:0] KindBracketOpen  = 5'd15;
  localparam logic [KindW-1:0] KindBracketClose = 5'd16;
  localparam logic [KindW-1:0] KindBraceOpen    = 5'd17;
  localparam logic [KindW-1:0] KindBraceClose   = 5'd18;

  // Characters that steer the scanner.
  localparam logic [ByteW-1:0] ChSlash     = "/";
  localparam logic [ByteW-1:0] ChQuote     = "\"";
  localparam logic [ByteW-1:0] ChUnder     = "_";
  localparam logic [ByteW-1:0] ChDot       = ".";
  localparam logic [ByteW-1:0] ChNewline   = "\n";
  localparam logic [ByteW-1:0] ChBackslash = "\\";
  localparam logic [ByteW-1:0] ChLowerA    = "a";
  localparam logic [ByteW-1:0] ChUpperA    = "A";
  localparam logic [ByteW-1:0] ChZero      = "0";
  localparam logic [ByteW-1:0] ChSpace     = " ";

  localparam int DirRowCount  = 25;
  localparam int RandomItems  = 190;
  localparam int HoldCycles   = 80;
  localparam int DrainCycles  = 10;
  localparam int DrainLimit   = 5000;
  localparam int PrintLimit   = 50;
  localparam string PunctSet  = "+*=@$.,;()[]{}";
  localparam tok_t NoToken    = '0;

  // One row of the directed table; typed rows carry their expected token.
  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             eot;
    bit               typed;
    bit               has_tok;
    tok_t             tok;
  } dir_row_t;

  // One expected token and its end-of-run flag.
  typedef struct packed {
    tok_t tok;
    logic last;
  } token_exp_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    source_byte_i = '0;
  logic                end_of_text_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [KindW-1:0]    token_kind_o;
  logic [PosW-1:0]     start_pos_o;
  logic [PosW-1:0]     end_pos_o;
  logic [LineW-1:0]    line_number_o;
  logic                last_of_run_o;

  // Side information that travels with each request.
  bit                  row_typed   = 1'b0;
  bit                  row_has_tok = 1'b0;
  tok_t                row_tok     = '0;

  // Scanner state of the predictor.
  mode_e               scan_st;
  logic [PosW-1:0]     tok_begin;
  logic [PosW-1:0]     byte_pos;
  logic [LineW-1:0]    line_ctr;
  logic                line_busy;
  tok_t                step_toks[$];

  token_exp_t          tokens_due[$];
  token_exp_t          oldest;
  logic [ByteW-1:0]    text_bytes[$];
  dir_row_t            dir_rows[DirRowCount];

  int                  err_count   = 0;
  int                  bytes_taken = 0;
  int                  tokens_got  = 0;
  int                  texts_done  = 0;
  int                  burst_left  = 0;
  bit                  hold_req    = 1'b0;

  source_byte_tokenizer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .source_byte_i (source_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .start_pos_o   (start_pos_o),
    .end_pos_o     (end_pos_o),
    .line_number_o (line_number_o),
    .last_of_run_o (last_of_run_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #30000000;
    $display("Timeout with %0d tokens still expected.", tokens_due.size());
    $display("** source_byte_tokenizer_top: FAILED **");
    $finish;
  end

  // Prints one line per mismatch, up to a limit, and counts them all.
  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < PrintLimit) begin
      $display("[%0t] mismatch, %s: got %0d, expected %0d", $time, what, got, want);
    end
    err_count++;
  endtask

  // Character classes of the scanner.
  function automatic bit is_digit(input logic [ByteW-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_label_start(input logic [ByteW-1:0] c);
    return c == ChUnder || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [KindW-1:0] punct_code(input logic [ByteW-1:0] c);
    case (c)
      "+":     return KindPlus;
      "*":     return KindStar;
      "=":     return KindEquals;
      "@":     return KindAt;
      "$":     return KindDollar;
      ".":     return KindDot;
      ",":     return KindComma;
      ";":     return KindSemicolon;
      "(":     return KindParenOpen;
      ")":     return KindParenClose;
      "[":     return KindBracketOpen;
      "]":     return KindBracketClose;
      "{":     return KindBraceOpen;
      "}":     return KindBraceClose;
      default: return KindNone;
    endcase
  endfunction

  // Line number that a token on the current line carries; it saturates.
  function automatic logic [LineW-1:0] next_line();
    return (line_ctr < LineMax) ? line_ctr + 16'd1 : LineMax;
  endfunction

  function automatic void add_token(input logic [KindW-1:0] kind,
                                    input logic [PosW-1:0] s, input logic [PosW-1:0] e);
    step_toks.push_back('{kind, s, e, next_line()});
    line_busy = 1'b1;
  endfunction

  function automatic void close_line(input logic [PosW-1:0] s, input logic [PosW-1:0] e);
    line_ctr = next_line();
    step_toks.push_back('{KindLine, s, e, line_ctr});
    line_busy = 1'b0;
  endfunction

  function automatic void clear_scanner();
    scan_st   = ModeIdle;
    tok_begin = '0;
    byte_pos  = '0;
    line_ctr  = '0;
    line_busy = 1'b0;
  endfunction

  // Scans a byte from the idle mode: it opens a token, emits a single one, or skips the byte.
  function automatic void scan_fresh(input logic [ByteW-1:0] c,
                                     input logic [PosW-1:0] p, input logic [PosW-1:0] np);
    logic [KindW-1:0] k;
    k = punct_code(c);
    scan_st = ModeIdle;
    if (c == ChNewline) begin
      close_line(p, np);
    end else if (c == ChSlash) begin
      scan_st   = ModeSlash;
      tok_begin = p;
    end else if (c == ChQuote) begin
      scan_st   = ModeString;
      tok_begin = np;
    end else if (is_label_start(c)) begin
      scan_st   = ModeLabel;
      tok_begin = p;
    end else if (is_digit(c)) begin
      scan_st   = ModeNumber;
      tok_begin = p;
    end else if (k != KindNone) begin
      add_token(k, p, np);
    end
  endfunction

  // Advances the scanner by one byte and leaves its tokens in step_toks.
  function automatic void tokenize_byte(input logic [ByteW-1:0] c, input logic eot);
    logic [PosW-1:0] p;
    logic [PosW-1:0] np;
    p  = byte_pos;
    np = (p < MaxPos) ? p + 17'd1 : MaxPos;
    step_toks.delete();
    case (scan_st)
      ModeSlash: begin
        if (c == ChSlash) scan_st = ModeComment;
        else scan_fresh(c, p, np);
      end
      ModeComment: begin
        if (c == ChNewline) begin
          add_token(KindComment, tok_begin, p);
          close_line(p, np);
          scan_st = ModeIdle;
        end
      end
      ModeString: begin
        if (c == ChQuote) begin
          add_token(KindString, tok_begin, p);
          scan_st = ModeIdle;
        end else if (c == ChBackslash) begin
          scan_st = ModeEscape;
        end
      end
      ModeEscape: scan_st = ModeString;
      ModeLabel: begin
        if (!(is_label_start(c) || is_digit(c))) begin
          add_token(KindLabel, tok_begin, p);
          scan_fresh(c, p, np);
        end
      end
      ModeNumber: begin
        if (!(c == ChDot || is_digit(c))) begin
          add_token(KindNumber, tok_begin, p);
          scan_fresh(c, p, np);
        end
      end
      default: scan_fresh(c, p, np);
    endcase
    // The last byte closes any open token and the current line.
    if (eot) begin
      case (scan_st)
        ModeComment:            add_token(KindComment, tok_begin, np);
        ModeString, ModeEscape: add_token(KindString, tok_begin, np);
        ModeLabel:              add_token(KindLabel, tok_begin, np);
        ModeNumber:             add_token(KindNumber, tok_begin, np);
        default: ;
      endcase
      if (line_busy) close_line(np, np);
      clear_scanner();
    end else begin
      byte_pos = np;
    end
  endfunction

  // Predict on every accepted request, then check every accepted token.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        tokenize_byte(source_byte_i, end_of_text_i);
        bytes_taken++;
        if (end_of_text_i) texts_done++;
        if (row_typed) begin
          if (row_has_tok) tokens_due.push_back('{row_tok, 1'b1});
        end else begin
          foreach (step_toks[i]) begin
            tokens_due.push_back('{step_toks[i], (i == step_toks.size() - 1)});
          end
        end
      end
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        tokens_got++;
        if (tokens_due.size() == 0) begin
          report_mismatch("token with none expected, kind", token_kind_o, 0);
        end else begin
          oldest = tokens_due.pop_front();
          if (token_kind_o !== oldest.tok.kind)
            report_mismatch("token_kind", token_kind_o, oldest.tok.kind);
          if (start_pos_o !== oldest.tok.start_pos)
            report_mismatch("start_pos", start_pos_o, oldest.tok.start_pos);
          if (end_pos_o !== oldest.tok.end_pos)
            report_mismatch("end_pos", end_pos_o, oldest.tok.end_pos);
          if (line_number_o !== oldest.tok.line)
            report_mismatch("line_number", line_number_o, oldest.tok.line);
          if (last_of_run_o !== oldest.last)
            report_mismatch("last_of_run", last_of_run_o, oldest.last);
        end
      end
    end
  end

  // Receiver: phases of no, light, even and heavy stalling, plus one long hold.
  initial begin
    int mode;
    int span;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 40);
      repeat (span) begin
        if (hold_req) begin
          out_stall_i <= 1'b1;
          repeat (HoldCycles) @(posedge clk_i);
          hold_req = 1'b0;
        end
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= 1'($urandom_range(0, 1));
          default: out_stall_i <= ($urandom_range(0, 4) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Offers one request and returns at the edge where it is taken.
  task automatic put_byte(input logic [ByteW-1:0] c, input logic eot,
                          input bit typed, input bit has_tok, input tok_t tok);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    source_byte_i <= c;
    end_of_text_i <= eot;
    row_typed     <= typed;
    row_has_tok   <= has_tok;
    row_tok       <= tok;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Sends text_bytes as one text, flagging its last byte.
  task automatic send_text();
    foreach (text_bytes[i]) begin
      put_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, 1'b0, NoToken);
    end
  endtask

  function automatic logic [ByteW-1:0] label_byte(input bit first);
    case ($urandom_range(0, first ? 2 : 3))
      0:       return ChLowerA + 8'($urandom_range(0, 25));
      1:       return ChUpperA + 8'($urandom_range(0, 25));
      2:       return ChUnder;
      default: return ChZero + 8'($urandom_range(0, 9));
    endcase
  endfunction

  // Builds a random text, mostly well-formed fragments with some noise.
  task automatic build_text();
    int target;
    int n;
    logic [ByteW-1:0] c;
    text_bytes.delete();
    target = $urandom_range(3, 20);
    while (text_bytes.size() < target) begin
      case ($urandom_range(0, 11))
        0, 1: begin
          text_bytes.push_back(label_byte(1'b1));
          repeat ($urandom_range(0, 5)) text_bytes.push_back(label_byte(1'b0));
        end
        2: begin
          text_bytes.push_back(ChZero + 8'($urandom_range(0, 9)));
          repeat ($urandom_range(0, 4)) begin
            text_bytes.push_back(($urandom_range(0, 3) == 0) ? ChDot
                                 : ChZero + 8'($urandom_range(0, 9)));
          end
        end
        3: begin
          text_bytes.push_back(ChQuote);
          n = $urandom_range(0, 6);
          repeat (n) begin
            case ($urandom_range(0, 5))
              0: begin
                text_bytes.push_back(ChBackslash);
                text_bytes.push_back(8'($urandom_range(32, 126)));
              end
              1:       text_bytes.push_back(ChNewline);
              default: text_bytes.push_back(8'($urandom_range(32, 126)));
            endcase
          end
          text_bytes.push_back(ChQuote);
        end
        4: begin
          text_bytes.push_back(ChSlash);
          text_bytes.push_back(ChSlash);
          repeat ($urandom_range(0, 5)) begin
            c = 8'($urandom_range(0, 255));
            text_bytes.push_back((c == ChNewline) ? ChSpace : c);
          end
          text_bytes.push_back(ChNewline);
        end
        5, 6: text_bytes.push_back(PunctSet[$urandom_range(0, PunctSet.len() - 1)]);
        7:    text_bytes.push_back(ChSpace);
        8:    text_bytes.push_back(ChNewline);
        9:    text_bytes.push_back(ChSlash);
        10:   text_bytes.push_back(8'($urandom_range(0, 255)));
        default: text_bytes.push_back(8'($urandom_range(128, 255)));
      endcase
    end
    // Sometimes the text stops inside an open token.
    case ($urandom_range(0, 7))
      0: begin
        text_bytes.push_back(ChQuote);
        if ($urandom_range(0, 1) == 1) text_bytes.push_back(ChBackslash);
      end
      1: begin
        text_bytes.push_back(ChSlash);
        text_bytes.push_back(ChSlash);
        text_bytes.push_back(label_byte(1'b0));
      end
      2: text_bytes.push_back(label_byte(1'b1));
      3: text_bytes.push_back(ChZero + 8'($urandom_range(0, 9)));
      4: text_bytes.push_back(ChSlash);
      default: ;
    endcase
  endtask

  // Main sequence: reset, directed table, random texts, drain.
  initial begin
    int  random_sent;
    int  waited;
    bit  hold_asked;
    random_sent = 0;
    hold_asked  = 1'b0;
    clear_scanner();

    // Typed rows hold an expected token read straight off the behavior; the
    // others go through the predictor. Rows 4 to 24 walk comments, strings
    // with an escape and a newline, a label, a number, a lone slash and
    // texts that end inside an open string, after a lone slash and in a label.
    dir_rows = '{
      {ChNewline,   1'b0, 1'b1, 1'b1, KindLine, 17'd0, 17'd1, 16'd1},
      {8'h00,       1'b0, 1'b1, 1'b0, NoToken},
      {8'hFF,       1'b0, 1'b1, 1'b0, NoToken},
      {8'("}"),     1'b0, 1'b1, 1'b1, KindBraceClose, 17'd3, 17'd4, 16'd2},
      {ChSlash,     1'b0, 1'b0, 1'b0, NoToken},
      {ChSlash,     1'b0, 1'b0, 1'b0, NoToken},
      {8'("x"),     1'b0, 1'b0, 1'b0, NoToken},
      {ChNewline,   1'b0, 1'b0, 1'b0, NoToken},
      {ChQuote,     1'b0, 1'b0, 1'b0, NoToken},
      {ChBackslash, 1'b0, 1'b0, 1'b0, NoToken},
      {ChQuote,     1'b0, 1'b0, 1'b0, NoToken},
      {ChNewline,   1'b0, 1'b0, 1'b0, NoToken},
      {ChQuote,     1'b0, 1'b0, 1'b0, NoToken},
      {8'("a"),     1'b0, 1'b0, 1'b0, NoToken},
      {ChUnder,     1'b0, 1'b0, 1'b0, NoToken},
      {8'("9"),     1'b0, 1'b0, 1'b0, NoToken},
      {8'("+"),     1'b0, 1'b0, 1'b0, NoToken},
      {8'("1"),     1'b0, 1'b0, 1'b0, NoToken},
      {ChDot,       1'b0, 1'b0, 1'b0, NoToken},
      {8'("5"),     1'b0, 1'b0, 1'b0, NoToken},
      {ChSlash,     1'b0, 1'b0, 1'b0, NoToken},
      {8'("("),     1'b0, 1'b0, 1'b0, NoToken},
      {ChQuote,     1'b1, 1'b0, 1'b0, NoToken},
      {ChSlash,     1'b1, 1'b1, 1'b0, NoToken},
      {8'("Z"),     1'b1, 1'b0, 1'b0, NoToken}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRowCount; r++) begin
      put_byte(dir_rows[r].ch, dir_rows[r].eot, dir_rows[r].typed,
               dir_rows[r].has_tok, dir_rows[r].tok);
    end

    // Random texts; once, early on, the receiver holds off so the block fills.
    while (random_sent < RandomItems) begin
      if (!hold_asked && random_sent > 40) begin
        hold_req   = 1'b1;
        hold_asked = 1'b1;
      end
      build_text();
      send_text();
      random_sent += text_bytes.size();
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (tokens_due.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (tokens_due.size() != 0) begin
      report_mismatch("tokens never produced", 0, tokens_due.size());
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d bytes in %0d texts and checked %0d tokens, %0d mismatches.",
             bytes_taken, texts_done, tokens_got, err_count);
    $display("Included the directed table, bursty input and one long receiver hold.");
    if (err_count == 0) begin
      $display("** source_byte_tokenizer_top: PASSED **");
    end else begin
      $display("** source_byte_tokenizer_top: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/sbt_pkg.sv
rtl/core/sbt_scan.sv
rtl/core/sbt_out.sv
rtl/core/source_byte_tokenizer_top.sv
rtl/core/sbt_checker.sv
dv/tb_source_byte_tokenizer_top.sv
